// File: src/csca_pkg.sv
// shared types, codes and geometry lookup for the cartridge addressing block
package csca_pkg;

    // fixed field widths
    localparam int CMD_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 19;
    localparam int PAGE_W     = 8;
    localparam int COUNTER_W  = 11;
    localparam int SHIFT_W    = 4;
    localparam int SIZE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3;
    localparam int TDATA_W    = 32;

    // parameter defaults
    localparam int BANK_ADDRESS_BITS_DEF = 19;
    localparam int QUEUE_DEPTH_DEF       = 4;

    // commands
    localparam logic [CMD_W-1:0] CMD_STROBE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADDR_BIT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ0    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ1    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE0   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WRITE1   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_PRELOAD  = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BANK0_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK1_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK0_WE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK1_WE   = 3'd3;

    // bank size codes
    localparam logic [SIZE_W-1:0] SIZE_UNUSED = 3'd0;
    localparam logic [SIZE_W-1:0] SIZE_64K    = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_128K   = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_256K   = 3'd3;
    localparam logic [SIZE_W-1:0] SIZE_512K   = 3'd4;

    typedef struct packed {
        logic [SHIFT_W-1:0]   shift;
        logic [COUNTER_W-1:0] count_mask;
        logic [ADDR_W-1:0]    bank_mask;
    } geom_t;

    // one bank operation handed from front to back
    typedef struct packed {
        logic              rd;
        logic              wr;
        logic              bank;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic geom_t geom_of(input logic [SIZE_W-1:0] code);
        geom_t g;
        unique case (code)
            SIZE_64K:  g = '{shift: 4'd8,  count_mask: 11'h0ff, bank_mask: 19'h0ffff};
            SIZE_128K: g = '{shift: 4'd9,  count_mask: 11'h1ff, bank_mask: 19'h1ffff};
            SIZE_256K: g = '{shift: 4'd10, count_mask: 11'h3ff, bank_mask: 19'h3ffff};
            SIZE_512K: g = '{shift: 4'd11, count_mask: 11'h7ff, bank_mask: 19'h7ffff};
            default:   g = '{shift: 4'd0,  count_mask: 11'h000, bank_mask: 19'h00000};
        endcase
        return g;
    endfunction

endpackage

// File: src/csca_ram.sv
// generic single-port ram with registered read
module csca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/csca_front.sv
// front end: accepts commands, keeps page/counter state, builds bank operations
module csca_front #(
    parameter int BANK_ADDRESS_BITS = csca_pkg::BANK_ADDRESS_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [csca_pkg::CMD_W-1:0]          command,
    input  logic [csca_pkg::BYTE_W-1:0]         value,
    input  logic                                preload_bank,
    input  logic [csca_pkg::ADDR_W-1:0]         preload_address,
    input  logic                                cfg_write,
    input  logic [csca_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csca_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  csca_pkg::qstat_t                    qstat,
    output logic                                push,
    output csca_pkg::op_t                       push_op
);

    localparam logic [csca_pkg::ADDR_W-1:0] STORE_MASK =
        csca_pkg::ADDR_W'((1 << BANK_ADDRESS_BITS) - 1);

    logic [csca_pkg::SIZE_W-1:0]    bank0_size_reg, bank1_size_reg;
    logic                           bank0_we_reg, bank1_we_reg;
    logic [csca_pkg::PAGE_W-1:0]    page_reg, page_next;
    logic [csca_pkg::COUNTER_W-1:0] counter_reg, counter_next;
    // strobe level and previous strobe are always written together
    logic                           strobe_reg, strobe_next;
    logic                           addr_bit_reg, addr_bit_next;

    csca_pkg::geom_t             acc_geom, pre_geom;
    logic                        acc_bank;
    logic [csca_pkg::ADDR_W-1:0] acc_addr;
    logic                        accept;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept;
    assign acc_bank = command[0];

    always_comb
    begin
        acc_geom = csca_pkg::geom_of(acc_bank ? bank1_size_reg : bank0_size_reg);
        pre_geom = csca_pkg::geom_of(preload_bank ? bank1_size_reg : bank0_size_reg);
        acc_addr = (({{(csca_pkg::ADDR_W - csca_pkg::PAGE_W){1'b0}}, page_reg}
                        << acc_geom.shift)
                    + {{(csca_pkg::ADDR_W - csca_pkg::COUNTER_W){1'b0}},
                       counter_reg & acc_geom.count_mask})
                   & acc_geom.bank_mask & STORE_MASK;
    end

    always_comb
    begin
        page_next     = page_reg;
        counter_next  = counter_reg;
        strobe_next   = strobe_reg;
        addr_bit_next = addr_bit_reg;
        push_op       = '0;
        unique case (command)
            csca_pkg::CMD_STROBE:
            begin
                strobe_next = value[0];
                if (value[0])
                begin
                    counter_next = '0;
                end
                if (value[0] && !strobe_reg)
                begin
                    page_next = {page_reg[csca_pkg::PAGE_W-2:0], addr_bit_reg};
                end
            end
            csca_pkg::CMD_ADDR_BIT:
            begin
                addr_bit_next = value[0];
            end
            csca_pkg::CMD_READ0, csca_pkg::CMD_READ1:
            begin
                push_op.rd   = 1'b1;
                push_op.bank = acc_bank;
                push_op.addr = acc_addr;
                if (!strobe_reg)
                begin
                    counter_next = counter_reg + 1'b1;
                end
            end
            csca_pkg::CMD_WRITE0, csca_pkg::CMD_WRITE1:
            begin
                // disabled write still reports the address and moves the counter while the strobe is low
                push_op.wr   = acc_bank ? bank1_we_reg : bank0_we_reg;
                push_op.bank = acc_bank;
                push_op.addr = acc_addr;
                push_op.data = value;
                if (!strobe_reg)
                begin
                    counter_next = counter_reg + 1'b1;
                end
            end
            csca_pkg::CMD_PRELOAD:
            begin
                push_op.wr   = 1'b1;
                push_op.bank = preload_bank;
                push_op.addr = preload_address & pre_geom.bank_mask & STORE_MASK;
                push_op.data = value;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg     <= '0;
            counter_reg  <= '0;
            strobe_reg   <= 1'b0;
            addr_bit_reg <= 1'b0;
        end
        else if (accept)
        begin
            page_reg     <= page_next;
            counter_reg  <= counter_next;
            strobe_reg   <= strobe_next;
            addr_bit_reg <= addr_bit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank0_size_reg <= csca_pkg::SIZE_UNUSED;
            bank1_size_reg <= csca_pkg::SIZE_64K;
            bank0_we_reg   <= 1'b0;
            bank1_we_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                csca_pkg::CFG_BANK0_SIZE: bank0_size_reg <= cfg_data;
                csca_pkg::CFG_BANK1_SIZE: bank1_size_reg <= cfg_data;
                csca_pkg::CFG_BANK0_WE:   bank0_we_reg   <= cfg_data[0];
                csca_pkg::CFG_BANK1_WE:   bank1_we_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: src/csca_queue.sv
// short operation queue between front and back
module csca_queue #(
    parameter int DEPTH = csca_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  csca_pkg::op_t    push_op,
    input  logic             pop,
    output csca_pkg::op_t    pop_op,
    output csca_pkg::qstat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    csca_pkg::op_t    slot [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign stat.full  = (count_reg == FULL);
    assign stat.empty = (count_reg == '0);
    assign pop_op     = slot[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/csca_back.sv
// back end: performs bank accesses in order and holds the result
module csca_back #(
    parameter int BANK_ADDRESS_BITS = csca_pkg::BANK_ADDRESS_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        avail,
    input  csca_pkg::op_t               op,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [csca_pkg::BYTE_W-1:0] read_data,
    output logic [csca_pkg::ADDR_W-1:0] access_address
);

    localparam int DEPTH = 1 << BANK_ADDRESS_BITS;

    // access stage: ram read data appears while an op sits here
    logic                        s1_valid_reg;
    logic                        s1_rd_reg;
    logic                        s1_bank_reg;
    logic [csca_pkg::ADDR_W-1:0] s1_addr_reg;

    logic                        out_valid_reg;
    logic [csca_pkg::BYTE_W-1:0] out_data_reg;
    logic [csca_pkg::ADDR_W-1:0] out_addr_reg;

    logic                        s1_move, s1_free;
    logic [csca_pkg::BYTE_W-1:0] rdata0, rdata1, s1_data;

    assign s1_move = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_free = !s1_valid_reg || s1_move;
    assign pop     = avail && s1_free;
    assign s1_data = !s1_rd_reg  ? '0 :
                     s1_bank_reg ? rdata1 : rdata0;

    csca_ram #(
        .WIDTH (csca_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_bank0 (
        .clk   (clk),
        .we    (pop && op.wr && !op.bank),
        .re    (pop && op.rd && !op.bank),
        .addr  (op.addr[BANK_ADDRESS_BITS-1:0]),
        .wdata (op.data),
        .rdata (rdata0)
    );

    csca_ram #(
        .WIDTH (csca_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_bank1 (
        .clk   (clk),
        .we    (pop && op.wr && op.bank),
        .re    (pop && op.rd && op.bank),
        .addr  (op.addr[BANK_ADDRESS_BITS-1:0]),
        .wdata (op.data),
        .rdata (rdata1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= pop;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_rd_reg   <= op.rd;
            s1_bank_reg <= op.bank;
            s1_addr_reg <= op.addr;
        end
        if (s1_move)
        begin
            out_data_reg <= s1_data;
            out_addr_reg <= s1_addr_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = out_data_reg;
    assign access_address = out_addr_reg;

endmodule

// File: src/cart_shift_counter_addressing.sv
// top level of the two-bank cartridge addressing block
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------------
//  s_axis   | s_axis_tvalid/s_axis_tready  | tuser command, tdata value/bank/address
//  m_axis   | m_axis_tvalid/m_axis_tready  | tdata read_data/access_address
//  cfg      | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// one command per cycle sustained while the queue is not full; each command gives one result transaction
// an accepted command passes the queue, then the ram access stage, then the output register
// page/counter state is updated by the front at accept time, memory work runs in the back
// reset clears control state only; bank contents are undefined until written
// output stalls fill the four-entry queue before s_axis_tready drops
module cart_shift_counter_addressing #(
    parameter int BANK_ADDRESS_BITS = csca_pkg::BANK_ADDRESS_BITS_DEF,
    parameter int QUEUE_DEPTH       = csca_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] value, [8] preload_bank, [27:9] preload_address, [31:28] zero
    input  logic [csca_pkg::TDATA_W-1:0]      s_axis_tdata,
    // [2:0] command
    input  logic [csca_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] read_data, [26:8] access_address, [31:27] zero
    output logic [csca_pkg::TDATA_W-1:0]      m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [csca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [csca_pkg::CFG_DATA_W-1:0]   cfg_data
);

    csca_pkg::qstat_t            qstat;
    csca_pkg::op_t               push_op, pop_op;
    logic                        push, pop;
    logic [csca_pkg::BYTE_W-1:0] read_data;
    logic [csca_pkg::ADDR_W-1:0] access_address;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    csca_front #(
        .BANK_ADDRESS_BITS (BANK_ADDRESS_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .command         (s_axis_tuser),
        .value           (s_axis_tdata[7:0]),
        .preload_bank    (s_axis_tdata[8]),
        .preload_address (s_axis_tdata[27:9]),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .qstat           (qstat),
        .push            (push),
        .push_op         (push_op)
    );

    csca_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .pop_op  (pop_op),
        .stat    (qstat)
    );

    csca_back #(
        .BANK_ADDRESS_BITS (BANK_ADDRESS_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .avail          (!qstat.empty),
        .op             (pop_op),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .read_data      (read_data),
        .access_address (access_address)
    );

    assign m_axis_tdata = {5'd0, access_address, read_data};

`ifndef NO_ASSERTIONS
    // an accepted command is in the queue next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !qstat.empty)
        else $error("accepted command missing from queue");

    // the queue only becomes full through an accepted command
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(qstat.full) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("queue filled without an accept");

    // reported addresses stay inside the bank store
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((access_address >> BANK_ADDRESS_BITS) == '0))
        else $error("access address beyond store size");

    // nothing is popped from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");
`endif

endmodule

// File: tb/tb_cart_shift_counter_addressing.sv
// self-checking stream testbench for the two-bank cartridge addressing block
`timescale 1ns / 1ps

module tb_cart_shift_counter_addressing;

    import csca_pkg::*;

    // size codes outside the documented range, both decode as an unused bank
    localparam logic [SIZE_W-1:0] SIZE_UNDEF_LO = 3'd5;
    localparam logic [SIZE_W-1:0] SIZE_UNDEF_HI = 3'd7;
    // command code the block has to ignore
    localparam logic [CMD_W-1:0]  CMD_UNKNOWN   = 3'd7;

    localparam int RANDOM_COMMANDS = 950;
    localparam int PHASES          = 8;
    // results pass queue, access stage and output register; leave some margin before touching config
    localparam int SETTLE_CYCLES   = 8;
    localparam int TIMEOUT_NS      = 5_000_000;

    // one command as sent, plus the result it is predicted to give
    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] value;
        logic              pbank;
        logic [ADDR_W-1:0] paddr;
        logic [BYTE_W-1:0] exp_data;
        logic [ADDR_W-1:0] exp_addr;
        bit                drain;
    } bus_command_t;

    typedef struct {
        logic [BYTE_W-1:0] read_data;
        logic [ADDR_W-1:0] access_address;
    } bus_result_t;

    // address window of one bank for a given size code
    typedef struct {
        int unsigned       shift;
        int unsigned       count_mask;
        logic [ADDR_W-1:0] bank_mask;
    } window_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size0;
        logic [SIZE_W-1:0] size1;
        logic              we0;
        logic              we1;
    } bank_setup_t;

    // every phase rewrites all four registers; sizes and enables hit both extremes
    bank_setup_t phase_setup [PHASES] = '{
        '{SIZE_512K,     SIZE_512K,     1'b1, 1'b1},
        '{SIZE_64K,      SIZE_128K,     1'b1, 1'b0},
        '{SIZE_256K,     SIZE_UNUSED,   1'b0, 1'b1},
        '{SIZE_128K,     SIZE_256K,     1'b1, 1'b1},
        '{SIZE_UNDEF_HI, SIZE_64K,      1'b1, 1'b1},
        '{SIZE_512K,     SIZE_64K,      1'b0, 1'b0},
        '{SIZE_UNUSED,   SIZE_512K,     1'b1, 1'b1},
        '{SIZE_64K,      SIZE_UNDEF_LO, 1'b1, 1'b1}
    };

    // clock, reset and every block input start at a known value
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata  = '0;
    logic [CMD_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // shadow of the block: configuration as after reset, control state cleared
    logic [SIZE_W-1:0]    mdl_size [2] = '{SIZE_UNUSED, SIZE_64K};
    logic                 mdl_we   [2] = '{1'b0, 1'b1};
    logic [PAGE_W-1:0]    mdl_page        = '0;
    logic [COUNTER_W-1:0] mdl_counter     = '0;
    logic                 mdl_strobe      = 1'b0;
    logic                 mdl_prev_strobe = 1'b0;
    logic                 mdl_addr_bit    = 1'b0;
    // bank contents keyed by {bank, address}; only written bytes exist
    logic [BYTE_W-1:0]    bank_bytes [logic [ADDR_W:0]];

    bus_command_t command_backlog [$];
    bus_result_t  awaited_results [$];
    bus_command_t in_flight;
    int           command_count = 0;
    int           error_count   = 0;
    bit           hold_next     = 1'b0;
    int           send_gap      = 0;
    int           accept_stall  = 0;
    bit           send_calm     = 1'b0;
    bit           accept_calm   = 1'b0;

    cart_shift_counter_addressing dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // idle draw per transaction; now and then switch between busy and quiet stretches
    function automatic int pick_gap(inout bit calm);
        if ($urandom_range(0, 31) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic window_t bank_window(input logic [SIZE_W-1:0] code);
        window_t w;
        case (code)
            SIZE_64K:  w = '{8,  32'h0ff, 19'h0ffff};
            SIZE_128K: w = '{9,  32'h1ff, 19'h1ffff};
            SIZE_256K: w = '{10, 32'h3ff, 19'h3ffff};
            SIZE_512K: w = '{11, 32'h7ff, 19'h7ffff};
            // unused and undefined codes pin every access to address 0
            default:   w = '{0,  32'h000, 19'h00000};
        endcase
        return w;
    endfunction

    // (page << shift) + masked counter, clipped to the bank size
    function automatic logic [ADDR_W-1:0] bank_address_of(input logic bank);
        window_t     w;
        int unsigned sum;
        w   = bank_window(mdl_size[bank]);
        sum = (32'(mdl_page) << w.shift)
            + (32'(mdl_counter) & w.count_mask);
        return ADDR_W'(sum) & w.bank_mask;
    endfunction

    // advance the shadow by one command and fill in the expected result
    task automatic predict_command(inout bus_command_t c);
        logic              bank;
        logic [ADDR_W-1:0] addr;
        window_t           w;
        c.exp_data = '0;
        c.exp_addr = '0;
        case (c.command)
            CMD_STROBE:
            begin
                mdl_strobe = c.value[0];
                // a high level always clears the counter, only a rising edge shifts
                if (mdl_strobe)
                    mdl_counter = '0;
                if (mdl_strobe && !mdl_prev_strobe)
                    mdl_page = {mdl_page[PAGE_W-2:0], mdl_addr_bit};
                mdl_prev_strobe = mdl_strobe;
            end
            CMD_ADDR_BIT:
                mdl_addr_bit = c.value[0];
            CMD_READ0, CMD_READ1, CMD_WRITE0, CMD_WRITE1:
            begin
                bank       = (c.command == CMD_READ1) || (c.command == CMD_WRITE1);
                addr       = bank_address_of(bank);
                c.exp_addr = addr;
                if (c.command == CMD_READ0 || c.command == CMD_READ1)
                    c.exp_data = bank_bytes[{bank, addr}];
                else if (mdl_we[bank])
                    bank_bytes[{bank, addr}] = c.value;
                // the counter only ripples while the strobe is low
                if (!mdl_strobe)
                    mdl_counter = mdl_counter + 1'b1;
            end
            CMD_PRELOAD:
            begin
                // write enable does not apply, counter untouched
                w          = bank_window(mdl_size[c.pbank]);
                addr       = c.paddr & w.bank_mask;
                c.exp_addr = addr;
                bank_bytes[{c.pbank, addr}] = c.value;
            end
            default: ;
        endcase
    endtask

    task automatic push_command(input bus_command_t c);
        c.drain   = hold_next;
        hold_next = 1'b0;
        predict_command(c);
        command_backlog.push_back(c);
        if (c.command != CMD_UNKNOWN)
            command_count++;
    endtask

    // reads only ever hit written bytes: a preload of the target goes first when needed
    task automatic queue_command(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] val,
                                 input logic pb, input logic [ADDR_W-1:0] pa);
        bus_command_t c;
        logic         bank;
        logic [ADDR_W-1:0] addr;
        bank = (cmd == CMD_READ1);
        if (cmd == CMD_READ0 || cmd == CMD_READ1)
        begin
            addr = bank_address_of(bank);
            if (!bank_bytes.exists({bank, addr}))
            begin
                c.command = CMD_PRELOAD;
                c.value   = BYTE_W'($urandom);
                c.pbank   = bank;
                c.paddr   = addr;
                push_command(c);
            end
        end
        c.command = cmd;
        c.value   = val;
        c.pbank   = pb;
        c.paddr   = pa;
        push_command(c);
    endtask

    // level commands carry random upper bits, only bit 0 matters
    task automatic queue_level(input logic [CMD_W-1:0] cmd, input logic level);
        queue_command(cmd, {7'($urandom), level}, 1'($urandom), ADDR_W'($urandom));
    endtask

    // the usual way to select a page: bit on the data pin, strobe pulse, repeat
    task automatic queue_page_load(input int nbits);
        for (int i = 0; i < nbits; i++)
        begin
            queue_level(CMD_ADDR_BIT, 1'($urandom));
            queue_level(CMD_STROBE, 1'b1);
            if ($urandom_range(0, 3) == 0)
                queue_level(CMD_STROBE, 1'b1);
            // sometimes leave the strobe high so the counter stays held
            if (i != nbits - 1 || $urandom_range(0, 4) != 0)
                queue_level(CMD_STROBE, 1'b0);
        end
    endtask

    task automatic queue_access_run(input int n);
        logic [CMD_W-1:0] cmd;
        int               r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 2)
                cmd = CMD_READ0;
            else if (r < 5)
                cmd = CMD_READ1;
            else if (r < 7)
                cmd = CMD_WRITE0;
            else if (r < 9)
                cmd = CMD_WRITE1;
            else
                cmd = CMD_PRELOAD;
            queue_command(cmd, BYTE_W'($urandom), 1'($urandom), ADDR_W'($urandom));
        end
    endtask

    // config write on the register channel; shadow follows at the handshake
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_BANK0_SIZE: mdl_size[0] = data;
            CFG_BANK1_SIZE: mdl_size[1] = data;
            CFG_BANK0_WE:   mdl_we[0]   = data[0];
            CFG_BANK1_WE:   mdl_we[1]   = data[0];
            default: ;
        endcase
    endtask

    // block is idle once nothing waits to be sent or to come back
    // checked on the falling edge so driver updates of the rising edge have landed
    task automatic wait_idle();
        while (command_backlog.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // command driver: one transaction per handshake, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                awaited_results.push_back('{in_flight.exp_data, in_flight.exp_addr});
                send_gap = pick_gap(send_calm);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                // a held command waits until every result so far is back
                else if (command_backlog.size() != 0
                         && !(command_backlog[0].drain && awaited_results.size() != 0))
                begin
                    in_flight      = command_backlog.pop_front();
                    s_axis_tdata  <= {4'b0, in_flight.paddr, in_flight.pbank, in_flight.value};
                    s_axis_tuser  <= in_flight.command;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor: random back-pressure, each result checked against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : result_check
        bus_result_t exp_res;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result transaction with nothing expected: tdata %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    exp_res = awaited_results.pop_front();
                    if (m_axis_tdata[7:0] !== exp_res.read_data)
                    begin
                        $error("read_data mismatch: expected %h, actual %h",
                               exp_res.read_data, m_axis_tdata[7:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[26:8] !== exp_res.access_address)
                    begin
                        $error("access_address mismatch: expected %h, actual %h",
                               exp_res.access_address, m_axis_tdata[26:8]);
                        error_count++;
                    end
                end
                accept_stall = pick_gap(accept_calm);
            end
            if (accept_stall > 0)
            begin
                accept_stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // stimulus sequencer: directed commands at reset config, then random phases
    initial
    begin : stimulus
        int base;
        int r;
        @(posedge rst_n);
        @(posedge clk);
        @(negedge clk);

        // bank 0 unused and write-protected, bank 1 64K and writable
        queue_command(CMD_PRELOAD, 8'hff, 1'b0, 19'h7ffff);  // masked to address 0
        queue_command(CMD_READ0,   8'h00, 1'b0, 19'h00000);
        queue_command(CMD_WRITE0,  8'h00, 1'b0, 19'h00000);  // protected, byte stays
        queue_command(CMD_READ0,   8'h00, 1'b1, 19'h7ffff);
        queue_command(CMD_PRELOAD, 8'h00, 1'b1, 19'h7ffff);
        queue_command(CMD_PRELOAD, 8'h80, 1'b1, 19'h00000);
        queue_command(CMD_ADDR_BIT, 8'hff, 1'b0, 19'h00000);
        queue_command(CMD_STROBE,  8'h01, 1'b0, 19'h00000);  // rising edge shifts a one in
        queue_command(CMD_STROBE,  8'hff, 1'b0, 19'h00000);  // still high: clear, no shift
        queue_command(CMD_WRITE1,  8'ha5, 1'b0, 19'h00000);  // counter held at zero
        hold_next = 1'b1;
        queue_command(CMD_READ1,   8'h00, 1'b0, 19'h00000);
        queue_command(CMD_STROBE,  8'hfe, 1'b0, 19'h00000);
        queue_command(CMD_ADDR_BIT, 8'h00, 1'b1, 19'h7ffff);
        queue_command(CMD_STROBE,  8'h01, 1'b0, 19'h00000);
        queue_command(CMD_STROBE,  8'h00, 1'b0, 19'h00000);
        queue_command(CMD_WRITE1,  8'hff, 1'b0, 19'h00000);
        queue_command(CMD_READ1,   8'h00, 1'b0, 19'h00000);
        queue_command(CMD_UNKNOWN, 8'hff, 1'b1, 19'h7ffff);
        queue_command(CMD_UNKNOWN, 8'h00, 1'b0, 19'h00000);
        queue_command(CMD_READ0,   8'h00, 1'b0, 19'h00000);
        queue_command(CMD_WRITE1,  8'h3c, 1'b0, 19'h00000);
        wait_idle();

        base = command_count;
        for (int p = 0; p < PHASES; p++)
        begin
            write_register(CFG_BANK0_SIZE, phase_setup[p].size0);
            write_register(CFG_BANK1_SIZE, phase_setup[p].size1);
            write_register(CFG_BANK0_WE,   CFG_DATA_W'(phase_setup[p].we0));
            write_register(CFG_BANK1_WE,   CFG_DATA_W'(phase_setup[p].we1));
            cfg_valid <= 1'b0;
            @(negedge clk);

            // mostly page selects followed by access bursts, some raw noise
            while (command_count - base < (p + 1) * RANDOM_COMMANDS / PHASES)
            begin
                hold_next = ($urandom_range(0, 39) == 0);
                r         = $urandom_range(0, 9);
                if (r < 5)
                begin
                    queue_page_load($urandom_range(1, 8));
                    queue_access_run($urandom_range(4, 24));
                end
                else if (r < 8)
                    queue_access_run($urandom_range(4, 24));
                else
                    repeat ($urandom_range(1, 6))
                        queue_command(CMD_W'($urandom), BYTE_W'($urandom),
                                      1'($urandom), ADDR_W'($urandom));
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
src/csca_pkg.sv
src/csca_ram.sv
src/csca_front.sv
src/csca_queue.sv
src/csca_back.sv
src/cart_shift_counter_addressing.sv
tb/tb_cart_shift_counter_addressing.sv
